// ----- rtl/packet_header_stripper_unit_macros.svh -----
// Assertion macros for the packet header stripper.
`ifndef PACKET_HEADER_STRIPPER_UNIT_MACROS_SVH
`define PACKET_HEADER_STRIPPER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define PHS_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("phs assertion failed");

`define PHS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("phs assertion failed");

`else

`define PHS_ASSERT_SAME(name, ante, cons)

`define PHS_ASSERT_NEXT(name, ante, cons)

`endif

`endif

// ----- rtl/phs_pkg.sv -----
package phs_pkg;

  localparam logic [7:0]  TAG_MASK     = 8'hBC;
  localparam logic [7:0]  TAG_SESSION  = 8'h84;
  localparam logic [7:0]  TAG_DATA     = 8'hA4;
  localparam logic [7:0]  PK_VER_A     = 8'h03;
  localparam logic [7:0]  PK_VER_B     = 8'h02;
  localparam logic [7:0]  ALG_VER      = 8'h01;
  localparam logic [31:0] INDEF_LEN    = 32'h7FFF_FFFF;
  localparam logic [3:0]  ALG_IDX      = 4'd9;
  localparam logic [3:0]  LAST_HDR_IDX = 4'd11;

  typedef enum logic [3:0] {
    PH_TAG  = 4'b0001,
    PH_LEN  = 4'b0010,
    PH_HEAD = 4'b0100,
    PH_BODY = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    CLS_OTHER = 2'd0,
    CLS_SESS  = 2'd1,
    CLS_DATA  = 2'd2
  } class_e;

  typedef enum logic [2:0] {
    KIND_PAYLOAD    = 3'd0,
    KIND_BAD_PK_VER = 3'd1,
    KIND_BAD_ALG    = 3'd2,
    KIND_EXTRA_DROP = 3'd3,
    KIND_CONV_DROP  = 3'd4
  } kind_e;

  typedef struct packed {
    phase_e phase;
    logic   session_seen;
  } phs_status_t;

endpackage

// ----- rtl/phs_in_reg.sv -----
module phs_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_valid_i,
  output logic       s_ready_o,
  input  logic [7:0] s_byte_i,
  output logic       item_valid_o,
  input  logic       item_ready_i,
  output logic [7:0] item_byte_o
);

  logic       valid_q;
  logic       valid_d;
  logic [7:0] byte_q;

  assign s_ready_o = !valid_q || item_ready_i;
  assign valid_d   = s_ready_o ? s_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // hold the byte until the parser takes it
  always_ff @(posedge clk_i) begin
    if (s_ready_o && s_valid_i) begin
      byte_q <= s_byte_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_byte_o  = byte_q;

endmodule

// ----- rtl/phs_parser.sv -----
module phs_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_conv_i,
  input  logic                 item_valid_i,
  output logic                 item_ready_o,
  input  logic [7:0]           item_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           out_byte_o,
  output logic [2:0]           out_kind_o,
  output phs_pkg::phs_status_t status_o
);

  logic            conv_q;
  phs_pkg::phase_e phase_q, phase_d;
  phs_pkg::class_e cls_q, cls_d;
  logic [2:0]      lbl_q, lbl_d;
  logic [31:0]     bytes_q, bytes_d, br_len, br_dec;
  logic [3:0]      hidx_q, hidx_d;
  logic            drop_q, drop_d;
  logic            seen_q, seen_d;
  logic            emit;
  logic            len_done;
  logic [7:0]      emit_byte;
  phs_pkg::kind_e  emit_kind;
  logic            out_free;
  logic            fire;
  logic            out_valid_q;
  logic [7:0]      out_byte_q;
  phs_pkg::kind_e  out_kind_q;
  logic [7:0]      b;
  logic [7:0]      tag_cls;

  assign out_free     = !out_valid_q || out_ready_i;
  assign item_ready_o = out_free;
  assign fire         = item_valid_i && out_free;
  assign b            = item_byte_i;
  assign tag_cls      = b & phs_pkg::TAG_MASK;
  assign br_dec       = (bytes_q != 32'd0) ? bytes_q - 32'd1 : bytes_q;

  always_comb begin
    phase_d   = phase_q;
    cls_d     = cls_q;
    lbl_d     = lbl_q;
    bytes_d   = bytes_q;
    hidx_d    = hidx_q;
    drop_d    = drop_q;
    seen_d    = seen_q;
    emit      = 1'b0;
    emit_byte = 8'd0;
    emit_kind = phs_pkg::KIND_PAYLOAD;
    len_done  = 1'b0;
    br_len    = bytes_q;

    case (phase_q)
      phs_pkg::PH_LEN: begin
        br_len  = {bytes_q[23:0], b};
        bytes_d = br_len;
        lbl_d   = lbl_q - 3'd1;
        if (lbl_q == 3'd1) begin
          len_done = 1'b1;
        end
      end
      phs_pkg::PH_HEAD: begin
        if (hidx_q == 4'd0 && b != phs_pkg::PK_VER_A && b != phs_pkg::PK_VER_B) begin
          emit      = 1'b1;
          emit_kind = phs_pkg::KIND_BAD_PK_VER;
        end else if (hidx_q == phs_pkg::ALG_IDX && b != phs_pkg::ALG_VER) begin
          emit      = 1'b1;
          emit_kind = phs_pkg::KIND_BAD_ALG;
        end
        bytes_d = br_dec;
        hidx_d  = hidx_q + 4'd1;
        if (hidx_q == phs_pkg::LAST_HDR_IDX) begin
          hidx_d  = 4'd0;
          seen_d  = 1'b1;
          drop_d  = 1'b0;
          phase_d = (br_dec != 32'd0) ? phs_pkg::PH_BODY : phs_pkg::PH_TAG;
        end
      end
      phs_pkg::PH_BODY: begin
        bytes_d = br_dec;
        if (!drop_q) begin
          emit      = 1'b1;
          emit_byte = b;
        end
        if (br_dec == 32'd0) begin
          phase_d = phs_pkg::PH_TAG;
        end
      end
      default: begin
        if (tag_cls == phs_pkg::TAG_SESSION) begin
          cls_d = phs_pkg::CLS_SESS;
        end else if (tag_cls == phs_pkg::TAG_DATA) begin
          cls_d = phs_pkg::CLS_DATA;
        end else begin
          cls_d = phs_pkg::CLS_OTHER;
        end
        case (b[1:0])
          2'd0:    lbl_d = 3'd1;
          2'd1:    lbl_d = 3'd2;
          2'd2:    lbl_d = 3'd4;
          default: lbl_d = 3'd0;
        endcase
        if (b[1:0] == 2'd3) begin
          br_len   = phs_pkg::INDEF_LEN;
          bytes_d  = phs_pkg::INDEF_LEN;
          len_done = 1'b1;
        end else begin
          bytes_d = 32'd0;
          phase_d = phs_pkg::PH_LEN;
        end
      end
    endcase

    if (len_done) begin
      if (cls_d == phs_pkg::CLS_SESS) begin
        if (seen_q || conv_q) begin
          drop_d    = 1'b1;
          phase_d   = (br_len != 32'd0) ? phs_pkg::PH_BODY : phs_pkg::PH_TAG;
          emit      = 1'b1;
          emit_kind = seen_q ? phs_pkg::KIND_EXTRA_DROP : phs_pkg::KIND_CONV_DROP;
        end else begin
          phase_d = phs_pkg::PH_HEAD;
          hidx_d  = 4'd0;
          drop_d  = 1'b0;
        end
      end else begin
        drop_d  = (cls_d != phs_pkg::CLS_DATA);
        phase_d = (br_len != 32'd0) ? phs_pkg::PH_BODY : phs_pkg::PH_TAG;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conv_q      <= 1'b0;
      phase_q     <= phs_pkg::PH_TAG;
      cls_q       <= phs_pkg::CLS_OTHER;
      lbl_q       <= 3'd0;
      bytes_q     <= 32'd0;
      hidx_q      <= 4'd0;
      drop_q      <= 1'b0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        conv_q <= cfg_conv_i;
      end
      if (fire) begin
        phase_q <= phase_d;
        cls_q   <= cls_d;
        lbl_q   <= lbl_d;
        bytes_q <= bytes_d;
        hidx_q  <= hidx_d;
        drop_q  <= drop_d;
        seen_q  <= seen_d;
      end
      if (out_free) begin
        out_valid_q <= fire && emit;
      end
    end
  end

  // load the result register only with a new result
  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      out_byte_q <= emit_byte;
      out_kind_q <= emit_kind;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign out_byte_o            = out_byte_q;
  assign out_kind_o            = out_kind_q;
  assign status_o.phase        = phase_q;
  assign status_o.session_seen = seen_q;

endmodule

// ----- rtl/packet_header_stripper_unit.sv -----
// Strips old-format packet headers from a byte stream. Each byte is one item on
// s_axis; the payload of session-key and data packets leaves on m_axis with
// tuser 0, and warnings (bad version bytes, dropped session-key packets) leave
// as a zero byte with a non-zero tuser kind. Other packets are consumed without
// output; header bytes give no payload. One byte is taken per cycle unless m_axis
// stalls; its result passes the input register, then the result register, to
// m_axis, and a stalled m_axis backs up through both registers.
// cfg carries conventional_mode and is always ready; write it only while idle.
`include "packet_header_stripper_unit_macros.svh"

module packet_header_stripper_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_data_i,       // conventional_mode
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,     // [7:0] in_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,     // [7:0] out_byte
  output logic [2:0] m_axis_tuser      // [2:0] out_kind
);

  logic                 item_valid;
  logic                 item_ready;
  logic [7:0]           item_byte;
  phs_pkg::phs_status_t status;

  assign cfg_ready_o = 1'b1;

  phs_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .s_byte_i     (s_axis_tdata),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_byte_o  (item_byte)
  );

  phs_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_conv_i   (cfg_data_i),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_byte_i  (item_byte),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_byte_o   (m_axis_tdata),
    .out_kind_o   (m_axis_tuser),
    .status_o     (status)
  );

  `PHS_ASSERT_SAME(a_warn_zero, m_axis_tvalid && m_axis_tuser != phs_pkg::KIND_PAYLOAD, m_axis_tdata == 8'd0)
  `PHS_ASSERT_NEXT(a_seen_sticky, status.session_seen, status.session_seen)
  `PHS_ASSERT_SAME(a_extra_after_seen, m_axis_tvalid && m_axis_tuser == phs_pkg::KIND_EXTRA_DROP, status.session_seen)

endmodule

// ----- tb/sv/phs_payload_check.sv -----
module phs_payload_check import phs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_o,
  input  logic       cfg_data_i,       // conventional_mode
  input  logic       s_axis_tvalid,
  input  logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,     // [7:0] in_byte
  input  logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  input  logic [7:0] m_axis_tdata,     // [7:0] out_byte
  input  logic [2:0] m_axis_tuser,     // [2:0] out_kind
  output int         fail_count_o,
  output int         pending_o
);

  localparam logic [1:0] LEN1 = 2'd0;
  localparam logic [1:0] LEN2 = 2'd1;
  localparam logic [1:0] LEN4 = 2'd2;

  typedef struct packed {
    logic [7:0] data;
    kind_e      kind;
  } strip_result_t;

  logic          conv_mode    = 1'b0;
  phase_e        phase_q      = PH_TAG;
  class_e        pkt_class    = CLS_OTHER;
  logic [2:0]    len_left     = '0;
  logic [31:0]   remaining    = '0;
  logic [3:0]    hdr_idx      = '0;
  logic          drop_q       = 1'b0;
  logic          session_seen = 1'b0;
  int            mismatches   = 0;
  strip_result_t expected_q[$];

  function automatic void open_body(input logic drop);
    drop_q  = drop;
    phase_q = (remaining != 0) ? PH_BODY : PH_TAG;
  endfunction

  task automatic close_length(output bit hit, output strip_result_t res);
    hit = 1'b0;
    res = '{data: 8'h00, kind: KIND_PAYLOAD};
    if (pkt_class == CLS_SESS) begin
      if (session_seen) begin
        open_body(1'b1);
        hit      = 1'b1;
        res.kind = KIND_EXTRA_DROP;
      end else if (conv_mode) begin
        open_body(1'b1);
        hit      = 1'b1;
        res.kind = KIND_CONV_DROP;
      end else begin
        phase_q = PH_HEAD;
        hdr_idx = '0;
        drop_q  = 1'b0;
      end
    end else begin
      open_body(pkt_class != CLS_DATA);
    end
  endtask

  task automatic strip_byte(input logic [7:0] b, output bit hit, output strip_result_t res);
    hit = 1'b0;
    res = '{data: 8'h00, kind: KIND_PAYLOAD};
    case (phase_q)
      PH_LEN: begin
        remaining = {remaining[23:0], b};
        len_left  = len_left - 3'd1;
        if (len_left == 0) close_length(hit, res);
      end
      PH_HEAD: begin
        if (hdr_idx == 0 && b != PK_VER_A && b != PK_VER_B) begin
          hit      = 1'b1;
          res.kind = KIND_BAD_PK_VER;
        end else if (hdr_idx == ALG_IDX && b != ALG_VER) begin
          hit      = 1'b1;
          res.kind = KIND_BAD_ALG;
        end
        if (remaining != 0) remaining = remaining - 32'd1;
        if (hdr_idx == LAST_HDR_IDX) begin
          hdr_idx      = '0;
          session_seen = 1'b1;
          open_body(1'b0);
        end else begin
          hdr_idx = hdr_idx + 4'd1;
        end
      end
      PH_BODY: begin
        if (remaining != 0) remaining = remaining - 32'd1;
        if (!drop_q) begin
          hit = 1'b1;
          res = '{data: b, kind: KIND_PAYLOAD};
        end
        if (remaining == 0) phase_q = PH_TAG;
      end
      default: begin
        if ((b & TAG_MASK) == TAG_SESSION) pkt_class = CLS_SESS;
        else if ((b & TAG_MASK) == TAG_DATA) pkt_class = CLS_DATA;
        else pkt_class = CLS_OTHER;
        remaining = '0;
        case (b[1:0])
          LEN1:    len_left = 3'd1;
          LEN2:    len_left = 3'd2;
          LEN4:    len_left = 3'd4;
          default: len_left = 3'd0;
        endcase
        if (len_left == 0) begin
          remaining = INDEF_LEN;
          close_length(hit, res);
        end else begin
          phase_q = PH_LEN;
        end
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    bit            hit;
    strip_result_t res;
    strip_result_t want;
    if (!rst_ni) begin
      conv_mode    = 1'b0;
      phase_q      = PH_TAG;
      pkt_class    = CLS_OTHER;
      len_left     = '0;
      remaining    = '0;
      hdr_idx      = '0;
      drop_q       = 1'b0;
      session_seen = 1'b0;
      mismatches   = 0;
      expected_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) conv_mode = cfg_data_i;
      if (s_axis_tvalid && s_axis_tready) begin
        strip_byte(s_axis_tdata, hit, res);
        if (hit) expected_q.push_back(res);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected item: out_byte %0h, out_kind %0d", m_axis_tdata, m_axis_tuser);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          if (m_axis_tdata !== want.data) begin
            $error("out_byte: expected %0h, got %0h", want.data, m_axis_tdata);
            mismatches++;
          end
          if (m_axis_tuser !== want.kind) begin
            $error("out_kind: expected %0d, got %0d", want.kind, m_axis_tuser);
            mismatches++;
          end
        end
      end
      fail_count_o <= mismatches;
      pending_o    <= expected_q.size();
    end
  end

endmodule

// ----- tb/sv/testbench.sv -----
module testbench;
  import phs_pkg::*;

  localparam logic [1:0] LEN1      = 2'd0;
  localparam logic [1:0] LEN2      = 2'd1;
  localparam logic [1:0] LEN4      = 2'd2;
  localparam logic [1:0] LEN_INDEF = 2'd3;
  localparam logic [7:0] FREE_TAG_BIT = 8'h40;
  localparam int STALL_LIMIT  = 2000;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS  = 215;

  typedef enum int {SINK_OPEN, SINK_MOSTLY, SINK_HALF, SINK_SPARSE} sink_mode_e;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       cfg_valid_i   = 1'b0;
  logic       cfg_data_i    = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic [7:0] s_axis_tdata  = 8'h00;
  logic       m_axis_tready = 1'b0;
  logic       cfg_ready_o;
  logic       s_axis_tready;
  logic       m_axis_tvalid;
  logic [7:0] m_axis_tdata;
  logic [2:0] m_axis_tuser;
  int         fail_count;
  int         pending_results;
  int         stall_cycles = 0;
  bit         hold_toggle  = 1'b0;
  logic [7:0] stream_q[$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  packet_header_stripper_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  phs_payload_check payload_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count_o  (fail_count),
    .pending_o     (pending_results)
  );

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : sink_pattern
    int unsigned stretch;
    int unsigned tick;
    sink_mode_e  mode;
    bit          hold_seen;
    logic        rdy;
    stretch   = 0;
    tick      = 0;
    mode      = SINK_OPEN;
    hold_seen = 1'b0;
    forever begin
      if (hold_seen != hold_toggle) begin
        hold_seen = hold_toggle;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end
      if (stretch == 0) begin
        mode    = sink_mode_e'($urandom_range(0, 3));
        stretch = $urandom_range(16, 96);
      end
      stretch--;
      tick++;
      case (mode)
        SINK_OPEN:   rdy = 1'b1;
        SINK_MOSTLY: rdy = ($urandom_range(0, 3) != 0);
        SINK_HALF:   rdy = tick[0];
        default:     rdy = ($urandom_range(0, 3) == 0);
      endcase
      m_axis_tready <= rdy;
      @(posedge clk_i);
    end
  end

  task automatic write_mode(input logic conv);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= conv;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic queue_packet(input logic [7:0] tag, input logic [31:0] len);
    stream_q.push_back(tag);
    case (tag[1:0])
      LEN1: stream_q.push_back(len[7:0]);
      LEN2: stream_q = {stream_q, len[15:8], len[7:0]};
      LEN4: stream_q = {stream_q, len[31:24], len[23:16], len[15:8], len[7:0]};
      default: ;
    endcase
    if (tag[1:0] != LEN_INDEF) repeat (len) stream_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic queue_random_packets(input int unsigned target);
    logic [7:0]  tag;
    logic [1:0]  code;
    logic [31:0] len;
    int unsigned pick;
    while (stream_q.size() < target) begin
      pick = $urandom_range(0, 7);
      len  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 24);
      code = (len > 255) ? 2'($urandom_range(LEN2, LEN4)) : 2'($urandom_range(LEN1, LEN4));
      if (pick < 4) begin
        tag = TAG_DATA | ($urandom_range(0, 1) ? FREE_TAG_BIT : 8'h00);
      end else if (pick < 6) begin
        do tag = 8'($urandom_range(0, 255));
        while ((tag & TAG_MASK) == TAG_SESSION || (tag & TAG_MASK) == TAG_DATA);
      end else begin
        tag = TAG_SESSION | ($urandom_range(0, 1) ? FREE_TAG_BIT : 8'h00);
      end
      queue_packet({tag[7:2], code}, len);
    end
  endtask

  task automatic send_stream();
    int unsigned burst;
    int unsigned gap;
    burst = 0;
    while (stream_q.size() > 0) begin
      if (burst == 0) burst = $urandom_range(1, 24);
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= stream_q.pop_front();
      @(posedge clk_i);
      while (!s_axis_tready) @(posedge clk_i);
      burst--;
      gap = (burst == 0 && $urandom_range(0, 3) != 0) ? $urandom_range(1, 8) : 0;
      if (gap != 0 || stream_q.size() == 0) s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // conventional mode: session-key packets are dropped, one of them empty
    write_mode(1'b1);
    queue_packet(TAG_SESSION | LEN1, 32'd1);
    queue_packet(TAG_SESSION | LEN1, 32'd0);
    send_stream();
    drain();

    // the one accepted session-key packet: short, with both version warnings
    write_mode(1'b0);
    stream_q = {stream_q, TAG_SESSION | FREE_TAG_BIT | LEN1, 8'h03, 8'h07};
    repeat (8) stream_q.push_back(8'($urandom_range(0, 255)));
    stream_q = {stream_q, 8'h00, 8'h00, 8'h10};
    stream_q = {stream_q, TAG_SESSION | LEN2, 8'h00, 8'h00};
    stream_q = {stream_q, TAG_DATA | LEN4, 8'h00, 8'h00, 8'h00, 8'h02, 8'h00, 8'hFF};
    send_stream();
    drain();

    for (int p = 0; p < 4; p++) begin
      write_mode(p % 2 == 0);
      if (p == 0) hold_toggle = ~hold_toggle;
      queue_random_packets(PHASE_ITEMS);
      send_stream();
      drain();
    end

    // indefinite length: warns on the tag, then the body never ends
    queue_packet(TAG_SESSION | LEN_INDEF, 32'd0);
    repeat (8) stream_q.push_back(8'($urandom_range(0, 255)));
    send_stream();
    drain();

    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
